// ----- hdl/checked_postfix_evaluator_assert.svh -----
// Assertion macros for the postfix evaluator checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CHECKED_POSTFIX_EVALUATOR_ASSERT_SVH
`define CHECKED_POSTFIX_EVALUATOR_ASSERT_SVH

// Same-cycle implication.
`define CPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("postfix evaluator assertion failed");

// Next-cycle implication.
`define CPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("postfix evaluator assertion failed");

`endif

// ----- hdl/cpe_pkg.sv -----
// Shared types and constants of the checked postfix evaluator.
// No dependencies; used by every module of the block except cpe_ram.
`default_nettype none

package cpe_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_OP   = 2'd1,
        MODE_END  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_MOD  = 3'd4,
        OP_CAT  = 3'd5,
        OP_BAD6 = 3'd6,
        OP_BAD7 = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OVF     = 3'd1,
        ST_DIV0    = 3'd2,
        ST_BADOP   = 3'd3,
        ST_FEW     = 3'd4,
        ST_BADEXPR = 3'd5,
        ST_FULL    = 3'd6,
        ST_RSVD    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        K_PUSH  = 2'd0,
        K_OP    = 2'd1,
        K_END   = 2'd2,
        K_BADOP = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        op_t         op;
        logic [63:0] number;
    } cmd_t;

    localparam logic [63:0] SIGN_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINUS_ONE  = 64'hFFFF_FFFF_FFFF_FFFF;
    // Largest factor that may still be multiplied by ten without overflow.
    localparam logic [63:0] FAC_LIMIT  = 64'd922337203685477580;

endpackage

`default_nettype wire

// ----- hdl/cpe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/cpe_front.sv -----
// Front end: accepts input beats, classifies them and queues commands.
// Depends on cpe_pkg.
`default_nettype none

module cpe_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [1:0]     mode,
    input  wire logic [2:0]     op_code,
    input  wire logic [63:0]    number,
    output logic                cmd_valid,
    output cpe_pkg::cmd_t       cmd,
    input  wire logic           cmd_pop
);

    cpe_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    cpe_pkg::cmd_t cls;

    always_comb
    begin
        cls.op     = cpe_pkg::op_t'(op_code);
        cls.number = number;
        unique case (cpe_pkg::mode_t'(mode))
            cpe_pkg::MODE_PUSH: cls.kind = cpe_pkg::K_PUSH;
            cpe_pkg::MODE_OP:
            begin
                if (op_code == cpe_pkg::OP_BAD6 || op_code == cpe_pkg::OP_BAD7)
                begin
                    cls.kind = cpe_pkg::K_BADOP;
                end
                else
                begin
                    cls.kind = cpe_pkg::K_OP;
                end
            end
            cpe_pkg::MODE_END:  cls.kind = cpe_pkg::K_END;
            default:            cls.kind = cpe_pkg::K_END;
        endcase
    end

    assign in_stall  = (cnt_reg == 2'd2);
    // A beat with the meaningless mode is taken and dropped here.
    assign push      = in_valid && !in_stall && (mode != cpe_pkg::MODE_NONE);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cpe_back.sv -----
// Back end: operand stack, checked arithmetic sequencer and result register.
// Depends on cpe_pkg and cpe_ram.
`default_nettype none

module cpe_back #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire cpe_pkg::cmd_t  cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [63:0]         value,
    output logic [2:0]          status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_MULEND = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_DIVEND = 8'b0010_0000,
        S_DIGIT  = 8'b0100_0000,
        S_CATADD = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             disc_reg, disc_next;
    logic [63:0]      top_reg, top_next;
    logic [63:0]      left_reg, left_next;
    cpe_pkg::op_t     op_reg, op_next;
    logic [65:0]      acc_reg, acc_next;
    logic [63:0]      ma_reg, ma_next;
    logic [63:0]      mb_reg, mb_next;
    logic             neg_reg, neg_next;
    logic             ovf_reg, ovf_next;
    logic             cat_reg, cat_next;
    logic [5:0]       step_reg, step_next;
    logic [63:0]      rem_reg, rem_next;
    logic [63:0]      dvd_reg, dvd_next;
    logic [63:0]      dvs_reg, dvs_next;
    logic [63:0]      fac_reg, fac_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      value_reg, value_next;
    cpe_pkg::status_t status_reg, status_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [63:0]      ram_rdata;

    logic [63:0]      left_in, mag_l, mag_r;
    logic [63:0]      add_s, sub_s, cat_s;
    logic             add_ovf, sub_ovf, cat_ovf;
    logic [65:0]      mul_sum, mul_limit;
    logic [64:0]      div_r, div_d;
    logic [63:0]      prod, quot, modr;
    logic             fail_en, finish_en;
    cpe_pkg::status_t fail_st;
    logic [63:0]      finish_val;

    cpe_ram #(
        .WIDTH (64),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The top of stack lives in top_reg; the RAM holds the entries below it.
    assign left_in = (state_reg == S_LOAD) ? ram_rdata : left_reg;
    assign mag_l   = left_in[63] ? (64'd0 - left_in) : left_in;
    assign mag_r   = top_reg[63] ? (64'd0 - top_reg) : top_reg;

    assign add_s   = left_in + top_reg;
    assign add_ovf = (left_in[63] == top_reg[63]) && (add_s[63] != left_in[63]);
    assign sub_s   = left_in - top_reg;
    assign sub_ovf = (left_in[63] != top_reg[63]) && (sub_s[63] != left_in[63]);
    assign cat_s   = left_reg + mag_r;
    assign cat_ovf = (left_reg[63] == mag_r[63]) && (cat_s[63] != left_reg[63]);

    assign mul_sum   = {acc_reg[64:0], 1'b0} + (mb_reg[63] ? {2'b00, ma_reg} : 66'd0);
    assign mul_limit = neg_reg ? {2'b00, cpe_pkg::SIGN_MIN} : {2'b00, cpe_pkg::MAX_POS};
    assign prod      = neg_reg ? (64'd0 - acc_reg[63:0]) : acc_reg[63:0];

    assign div_r = {rem_reg, dvd_reg[63]};
    assign div_d = div_r - {1'b0, dvs_reg};
    assign quot  = neg_reg ? (64'd0 - dvd_reg) : dvd_reg;
    assign modr  = (left_reg[63] && (rem_reg != 64'd0)) ? (dvs_reg - rem_reg) : rem_reg;

    assign ram_waddr = AW'(count_reg - CW'(1));
    assign ram_raddr = AW'(count_reg - CW'(2));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        disc_next      = disc_reg;
        top_next       = top_reg;
        left_next      = left_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        neg_next       = neg_reg;
        ovf_next       = ovf_reg;
        cat_next       = cat_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        fac_next       = fac_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        cmd_pop        = 1'b0;
        fail_en        = 1'b0;
        fail_st        = cpe_pkg::ST_OK;
        finish_en      = 1'b0;
        finish_val     = 64'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == cpe_pkg::K_END)
                    begin
                        count_next = '0;
                        disc_next  = 1'b0;
                        if (!disc_reg)
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == CW'(1))
                            begin
                                value_next  = top_reg;
                                status_next = cpe_pkg::ST_OK;
                            end
                            else
                            begin
                                value_next  = 64'd0;
                                status_next = cpe_pkg::ST_BADEXPR;
                            end
                        end
                    end
                    else if (!disc_reg)
                    begin
                        unique case (cmd.kind)
                            cpe_pkg::K_PUSH:
                            begin
                                if (count_reg >= CW'(STACK_DEPTH))
                                begin
                                    fail_en = 1'b1;
                                    fail_st = cpe_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ram_we     = (count_reg != '0);
                                    top_next   = cmd.number;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            cpe_pkg::K_BADOP:
                            begin
                                fail_en = 1'b1;
                                fail_st = cpe_pkg::ST_BADOP;
                            end
                            default:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    fail_en = 1'b1;
                                    fail_st = cpe_pkg::ST_FEW;
                                end
                                else
                                begin
                                    op_next    = cmd.op;
                                    state_next = S_LOAD;
                                end
                            end
                        endcase
                    end
                end
            end

            S_LOAD:
            begin
                left_next = ram_rdata;
                neg_next  = ram_rdata[63] ^ top_reg[63];
                step_next = 6'd0;
                unique case (op_reg)
                    cpe_pkg::OP_ADD:
                    begin
                        fail_en    = add_ovf;
                        fail_st    = cpe_pkg::ST_OVF;
                        finish_en  = !add_ovf;
                        finish_val = add_s;
                    end
                    cpe_pkg::OP_SUB:
                    begin
                        fail_en    = sub_ovf;
                        fail_st    = cpe_pkg::ST_OVF;
                        finish_en  = !sub_ovf;
                        finish_val = sub_s;
                    end
                    cpe_pkg::OP_MUL:
                    begin
                        ma_next    = mag_l;
                        mb_next    = mag_r;
                        acc_next   = 66'd0;
                        ovf_next   = 1'b0;
                        cat_next   = 1'b0;
                        state_next = S_MUL;
                    end
                    cpe_pkg::OP_DIV, cpe_pkg::OP_MOD:
                    begin
                        if (top_reg == 64'd0)
                        begin
                            fail_en = 1'b1;
                            fail_st = cpe_pkg::ST_DIV0;
                        end
                        else if (op_reg == cpe_pkg::OP_DIV && ram_rdata == cpe_pkg::SIGN_MIN
                                 && top_reg == cpe_pkg::MINUS_ONE)
                        begin
                            fail_en = 1'b1;
                            fail_st = cpe_pkg::ST_OVF;
                        end
                        else
                        begin
                            rem_next   = 64'd0;
                            dvd_next   = mag_l;
                            dvs_next   = mag_r;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        if (top_reg == cpe_pkg::SIGN_MIN)
                        begin
                            fail_en = 1'b1;
                            fail_st = cpe_pkg::ST_OVF;
                        end
                        else
                        begin
                            fac_next   = 64'd1;
                            state_next = S_DIGIT;
                        end
                    end
                endcase
            end

            S_DIGIT:
            begin
                // The factor grows to the first power of ten above |right|.
                if (fac_reg <= mag_r)
                begin
                    if (fac_reg > cpe_pkg::FAC_LIMIT)
                    begin
                        fail_en = 1'b1;
                        fail_st = cpe_pkg::ST_OVF;
                    end
                    else
                    begin
                        fac_next = {fac_reg[60:0], 3'b000} + {fac_reg[62:0], 1'b0};
                    end
                end
                else
                begin
                    ma_next    = mag_l;
                    mb_next    = fac_reg;
                    neg_next   = left_reg[63];
                    acc_next   = 66'd0;
                    ovf_next   = 1'b0;
                    cat_next   = 1'b1;
                    step_next  = 6'd0;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                // One multiplier bit per cycle, MSB first; overflow is sticky.
                mb_next   = {mb_reg[62:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (!ovf_reg)
                begin
                    if (mul_sum > mul_limit)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mul_sum;
                    end
                end
                if (step_reg == 6'd63)
                begin
                    state_next = S_MULEND;
                end
            end

            S_MULEND:
            begin
                if (ovf_reg)
                begin
                    fail_en = 1'b1;
                    fail_st = cpe_pkg::ST_OVF;
                end
                else if (cat_reg)
                begin
                    left_next  = prod;
                    state_next = S_CATADD;
                end
                else
                begin
                    finish_en  = 1'b1;
                    finish_val = prod;
                end
            end

            S_CATADD:
            begin
                fail_en    = cat_ovf;
                fail_st    = cpe_pkg::ST_OVF;
                finish_en  = !cat_ovf;
                finish_val = cat_s;
            end

            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                step_next = step_reg + 6'd1;
                if (!div_d[64])
                begin
                    rem_next = div_d[63:0];
                    dvd_next = {dvd_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = div_r[63:0];
                    dvd_next = {dvd_reg[62:0], 1'b0};
                end
                if (step_reg == 6'd63)
                begin
                    state_next = S_DIVEND;
                end
            end

            S_DIVEND:
            begin
                finish_en  = 1'b1;
                finish_val = (op_reg == cpe_pkg::OP_DIV) ? quot : modr;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fail_en)
        begin
            out_valid_next = 1'b1;
            value_next     = 64'd0;
            status_next    = fail_st;
            count_next     = '0;
            disc_next      = 1'b1;
            state_next     = S_IDLE;
        end
        else if (finish_en)
        begin
            top_next   = finish_val;
            count_next = count_reg - CW'(1);
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            disc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            disc_reg      <= disc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        left_reg   <= left_next;
        op_reg     <= op_next;
        acc_reg    <= acc_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        cat_reg    <= cat_next;
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        fac_reg    <= fac_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ----- hdl/checked_postfix_evaluator.sv -----
// Checked postfix evaluator: usage summary and top-level wiring.
// Input channel: in_valid/in_stall with mode, op_code and number; a beat is taken
// when in_valid is high and in_stall low. Output channel: out_valid/out_stall
// with value and status, at most one result beat per input beat.
// A two-entry command queue sits between the front end and the execution unit,
// so input beats keep being taken while an operation runs or a result waits,
// until both entries are filled.
// The execution unit multiplies with a bit-serial multiplier and divides with a
// restoring divider, one bit per cycle, and reads the operand below the top of
// stack through the single read port of the stack RAM.
// Results leave through an output register; a result holds while out_stall is
// high, and the unit takes no new command until the result is gone.
// Reset (rst_n low, asynchronous) empties the stack, the queue and the output
// register and ends any dropping after an error; stack RAM contents are not
// cleared and need no clearing pass.
`default_nettype none

module checked_postfix_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [2:0]  op_code,
    input  wire logic [63:0] number,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value,
    output logic [2:0]       status
);

    logic          cmd_valid;
    logic          cmd_pop;
    cpe_pkg::cmd_t cmd;

    cpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .op_code   (op_code),
        .number    (number),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cpe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- hdl/cpe_checker.sv -----
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on cpe_pkg and checked_postfix_evaluator_assert.svh.
`default_nettype none

`include "checked_postfix_evaluator_assert.svh"

module cpe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  mode,
    input wire logic [2:0]  op_code,
    input wire logic [63:0] number,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] value,
    input wire logic [2:0]  status
);

    `CPE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(value) && $stable(status))
    `CPE_ASSERT_NXT(a_in_hold, in_valid && in_stall,
        in_valid && $stable(mode) && $stable(op_code) && $stable(number))
    `CPE_ASSERT_IMP(a_err_zero, out_valid && (status != cpe_pkg::ST_OK), value == 64'd0)
    `CPE_ASSERT_IMP(a_status_code, out_valid, status != cpe_pkg::ST_RSVD)
    // The output register leaves at most one result per cycle after a free slot.
    `CPE_ASSERT_NXT(a_one_result, out_valid && !out_stall && !in_valid && !in_stall
        && $past(!in_valid), !out_valid || !$past(out_valid, 2) || $past(out_stall, 2)
        || !$past(out_valid))

endmodule

bind checked_postfix_evaluator cpe_checker u_cpe_checker (.*);

`default_nettype wire
